### rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// Sequential list engine package
// Shared widths, command codes and the control/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

	// List capacity and derived widths.
	localparam int CAPACITY = 128;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = $clog2(CAPACITY + 1);

	// Payload field widths of the channels.
	localparam int CMD_W  = 3;
	localparam int POS_W  = 8;
	localparam int DATA_W = 32;
	localparam int LEN_W  = 8;

	// Width that holds both a position and a length with room for one more.
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the accepted item, clear results
		logic init_ins;  // start an upward shift from the list end
		logic init_del;  // start a downward shift at the position
		logic init_find; // start a scan at the list head
		logic step;      // one move or scan step
		logic rd_pos;    // read the entry at the position
		logic cap_rd;    // capture the read data as the result
		logic put_val;   // write the value at the position
		logic cnt_inc;
		logic cnt_dec;
		logic cnt_clr;
		logic set_err;
		logic out_load;  // copy the result into the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             ins_ok;
		logic             pos_ok;
		logic             busy;
	} dp_sts_t;

endpackage

### rtl/sle_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one list command per beat.
// ----------------------------------------------------------------------------
interface sle_req_if import sle_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output command, output position, output value, input ready);
	modport sink (input valid, input command, input position, input value, output ready);
endinterface

### rtl/sle_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one command result per beat.
// ----------------------------------------------------------------------------
interface sle_rsp_if import sle_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     status;
	logic signed [DATA_W-1:0] read_value;
	logic [LEN_W-1:0]         found_position;
	logic [LEN_W-1:0]         list_length;
	logic                     is_empty;

	modport source (output valid, output status, output read_value, output found_position,
		output list_length, output is_empty, input ready);
	modport sink (input valid, input status, input read_value, input found_position,
		input list_length, input is_empty, output ready);
endinterface

### rtl/sle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/sle_datapath.sv
// ----------------------------------------------------------------------------
// List datapath
// Entry RAM, length and index counters, shift and scan addressing, result and
// output registers.
// ----------------------------------------------------------------------------
module sle_datapath import sle_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CMD_W-1:0]         command,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	input  dp_cmd_t                  cmd,
	output dp_sts_t                  sts,
	output logic                     status,
	output logic signed [DATA_W-1:0] read_value,
	output logic [LEN_W-1:0]         found_position,
	output logic [LEN_W-1:0]         list_length,
	output logic                     is_empty
);
	logic [CMD_W-1:0]         cmd_q;
	logic [POS_W-1:0]         pos_q;
	logic [DATA_W-1:0]        val_q;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            idx_q;
	logic                     pend_q;
	logic [AW-1:0]            pend_addr_q;
	logic                     status_q;
	logic [DATA_W-1:0]        rdv_q;
	logic [CW-1:0]            found_q;
	logic                     o_status_q;
	logic [DATA_W-1:0]        o_rdv_q;
	logic [LEN_W-1:0]         o_found_q;
	logic [LEN_W-1:0]         o_len_q;
	logic                     o_empty_q;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [DATA_W-1:0]        ram_wdata;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;

	logic [CMPW-1:0]          pos_w;
	logic [CMPW-1:0]          cnt_w;
	logic [CMPW-1:0]          idx_w;
	logic [AW-1:0]            pos_m1;
	logic [AW-1:0]            idx_m1;
	logic                     hit;
	logic                     more;
	logic                     find_hit;

	sle_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Common-width views of position, length and index.
	assign pos_w  = CMPW'(pos_q);
	assign cnt_w  = CMPW'(cnt_q);
	assign idx_w  = CMPW'(idx_q);
	assign pos_m1 = AW'(pos_q - POS_W'(1));
	assign idx_m1 = AW'(idx_q - CW'(1));
	assign hit    = (ram_rdata == val_q);

	// Whether the running shift or scan still has an entry to read.
	always_comb begin
		unique case (cmd_q)
			CMD_INSERT: more = (idx_w >= pos_w);
			CMD_DELETE: more = (idx_w < cnt_w);
			CMD_FIND:   more = (idx_w < cnt_w) && (found_q == '0) && !(pend_q && hit);
			default:    more = 1'b0;
		endcase
	end

	assign find_hit = cmd.step && pend_q && hit && (cmd_q == CMD_FIND) && (found_q == '0);

	// Status toward the controller.
	assign sts.cmd    = cmd_q;
	assign sts.ins_ok = (pos_q != '0) && (pos_w <= cnt_w + CMPW'(1)) &&
		(cnt_w < CMPW'(CAPACITY));
	assign sts.pos_ok = (pos_q != '0) && (pos_w <= cnt_w);
	assign sts.busy   = more || pend_q;

	// RAM port selection: a shift writes the entry that it read in the cycle before.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		if (cmd.rd_pos) begin
			ram_re    = 1'b1;
			ram_raddr = pos_m1;
		end else if (cmd.step && more) begin
			ram_re    = 1'b1;
			ram_raddr = (cmd_q == CMD_INSERT) ? idx_m1 : idx_q[AW-1:0];
		end
		if (cmd.step && pend_q && (cmd_q == CMD_INSERT || cmd_q == CMD_DELETE)) begin
			ram_we    = 1'b1;
			ram_waddr = pend_addr_q;
		end else if (cmd.put_val) begin
			ram_we    = 1'b1;
			ram_waddr = pos_m1;
			ram_wdata = val_q;
		end
	end

	// Length, walk index and pending-write flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.init_ins) begin
				idx_q  <= cnt_q;
				pend_q <= 1'b0;
			end else if (cmd.init_del) begin
				idx_q  <= CW'(pos_q);
				pend_q <= 1'b0;
			end else if (cmd.init_find) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
			end else if (cmd.step) begin
				pend_q <= more;
				if (more) begin
					idx_q <= (cmd_q == CMD_INSERT) ? idx_q - CW'(1) : idx_q + CW'(1);
				end
			end
		end
	end

	// Item, result and output registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= command;
			pos_q    <= position;
			val_q    <= value;
			status_q <= 1'b0;
			rdv_q    <= '0;
			found_q  <= '0;
		end else begin
			if (cmd.set_err) begin
				status_q <= 1'b1;
			end
			if (cmd.cap_rd) begin
				rdv_q <= ram_rdata;
			end
			if (find_hit) begin
				found_q <= CW'(pend_addr_q) + CW'(1);
			end
		end
		if (cmd.step && more) begin
			unique case (cmd_q)
				CMD_INSERT: pend_addr_q <= idx_q[AW-1:0];
				CMD_DELETE: pend_addr_q <= idx_m1;
				default:    pend_addr_q <= idx_q[AW-1:0];
			endcase
		end
		if (cmd.out_load) begin
			o_status_q <= status_q;
			o_rdv_q    <= rdv_q;
			o_found_q  <= LEN_W'(found_q);
			o_len_q    <= LEN_W'(cnt_q);
			o_empty_q  <= (cnt_q == '0);
		end
	end

	assign status         = o_status_q;
	assign read_value     = o_rdv_q;
	assign found_position = o_found_q;
	assign list_length    = o_len_q;
	assign is_empty       = o_empty_q;

	// The length never passes the capacity.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("list length above capacity");

	// A shift never reads the entry it writes in the same cycle.
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("RAM read and write collide");

	// Growing the list only happens on a full-capacity check that passed.
	a_inc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (cmd_q == CMD_INSERT && cnt_w < CMPW'(CAPACITY)))
		else $error("length increment without room");

	// Shrinking the list only happens on a nonempty list.
	a_dec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> (cmd_q == CMD_DELETE && cnt_q != '0))
		else $error("length decrement on empty list");
endmodule

### rtl/sle_ctrl.sv
// ----------------------------------------------------------------------------
// List controller
// State machine that sequences each command through the datapath and owns
// the request ready and response valid handshakes.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_MOVE   = 3'd2;
	localparam logic [2:0] S_PUT    = 3'd3;
	localparam logic [2:0] S_FIND   = 3'd4;
	localparam logic [2:0] S_RDCAP  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				unique case (sts.cmd)
					CMD_INSERT: begin
						if (sts.ins_ok) begin
							cmd.init_ins = 1'b1;
							state_d      = S_MOVE;
						end else begin
							cmd.set_err = 1'b1;
						end
					end
					CMD_READ: begin
						if (sts.pos_ok) begin
							cmd.rd_pos = 1'b1;
							state_d    = S_RDCAP;
						end else begin
							cmd.set_err = 1'b1;
						end
					end
					CMD_DELETE: begin
						if (sts.pos_ok) begin
							cmd.init_del = 1'b1;
							state_d      = S_MOVE;
						end else begin
							cmd.set_err = 1'b1;
						end
					end
					CMD_FIND: begin
						cmd.init_find = 1'b1;
						state_d       = S_FIND;
					end
					CMD_CLEAR: begin
						cmd.cnt_clr = 1'b1;
					end
					default: begin
						cmd.set_err = 1'b1;
					end
				endcase
			end
			S_MOVE: begin
				cmd.step = 1'b1;
				if (!sts.busy) begin
					if (sts.cmd == CMD_INSERT) begin
						state_d = S_PUT;
					end else begin
						cmd.cnt_dec = 1'b1;
						state_d     = S_DONE;
					end
				end
			end
			S_PUT: begin
				cmd.put_val = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = S_DONE;
			end
			S_FIND: begin
				cmd.step = 1'b1;
				if (!sts.busy) begin
					state_d = S_DONE;
				end
			end
			S_RDCAP: begin
				cmd.cap_rd = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and response valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && out_valid_q) |-> out_ready)
		else $error("response overwritten while stalled");

	// An accepted command is decoded in the next cycle.
	a_load_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DECODE))
		else $error("accepted command not decoded");

	// Steps stay inside the walking states.
	a_step_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (state_q == S_MOVE || state_q == S_FIND))
		else $error("walk step outside a walking state");
endmodule

### rtl/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// Sequential list engine
// Fixed-capacity ordered list of signed 32-bit entries held in a RAM.
// ----------------------------------------------------------------------------
// Usage: each request beat carries command, position and value; each command
// gives exactly one response beat with status, read_value, found_position,
// list_length and is_empty. Commands are handled one at a time in order.
// The entry RAM moves or compares one entry per cycle through its single
// read port.
// The request side is ready whenever the engine is idle; a finished response
// sits in an output register, so the next request is taken while it waits.
// When the receiver stalls, the following response waits in the engine and
// no further request is accepted until it has moved to the output register.
// Reset (arst_n low) empties the list and drops any pending response; the
// RAM contents are not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module sequential_list_engine import sle_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	sle_req_if.sink   req,
	sle_rsp_if.source rsp
);
	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	sle_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.command        (req.command),
		.position       (req.position),
		.value          (req.value),
		.cmd            (dp_cmd),
		.sts            (dp_sts),
		.status         (rsp.status),
		.read_value     (rsp.read_value),
		.found_position (rsp.found_position),
		.list_length    (rsp.list_length),
		.is_empty       (rsp.is_empty)
	);
endmodule
